[rtl/ile_pkg.sv]
// Package for the indexed list engine.
// Holds the command and status codes, the beat types and the sequencer states.
// No dependencies.
package ile_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int POS_W          = 6;

  localparam logic [2:0] CMD_APPEND  = 3'd0;
  localparam logic [2:0] CMD_GET     = 3'd1;
  localparam logic [2:0] CMD_SET     = 3'd2;
  localparam logic [2:0] CMD_REMOVE  = 3'd3;
  localparam logic [2:0] CMD_REVERSE = 3'd4;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_OOB  = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [POS_W-1:0] position;
    logic [31:0]      item_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [6:0]  entry_count;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GET_WAIT,
    S_RM_SHIFT,
    S_REV_LO,
    S_REV_HI,
    S_REV_NXT,
    S_REV_LAST
  } state_t;

endpackage

[rtl/ile_mem.sv]
// Entry store of the indexed list engine: one write port, one read port,
// read data registered. Depends on ile_pkg for defaults.
module ile_mem
  import ile_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/ile_ctrl.sv]
// Command sequencer of the indexed list engine: decodes commands, keeps the
// count, walks the entry store for remove and reverse. Depends on ile_pkg.
module ile_ctrl
  import ile_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  request,
  output logic                  done,
  output rsp_t                  result,
  output logic                  mem_we,
  output logic [AW-1:0]         mem_waddr,
  output logic [DATA_WIDTH-1:0] mem_wdata,
  output logic                  mem_re,
  output logic [AW-1:0]         mem_raddr,
  input  logic [DATA_WIDTH-1:0] mem_rdata
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam int XW   = CW + 1;
  localparam int RW   = AW + 1;

  state_t                state, state_next;
  logic [CW-1:0]         count, count_next;
  logic [AW-1:0]         lo, lo_next;
  logic [AW-1:0]         hi, hi_next;
  logic [DATA_WIDTH-1:0] tmp, tmp_next;

  logic                  fin;
  logic [1:0]            fin_status;
  logic [31:0]           fin_read;

  logic [CMPW-1:0]       pos_ext;
  logic [CMPW-1:0]       cnt_ext;
  logic                  in_range;
  logic [AW-1:0]         pos_addr;
  logic [CMPW-1:0]       pos_inc;
  logic [DATA_WIDTH-1:0] word;
  logic [XW-1:0]         idx_plus2;
  logic                  rm_more;
  logic [RW-1:0]         lo_plus2;
  logic                  rev_more;

  assign busy      = (state != S_IDLE);
  assign pos_ext   = CMPW'(request.position);
  assign cnt_ext   = CMPW'(count);
  assign in_range  = (pos_ext < cnt_ext);
  assign pos_addr  = AW'(request.position);
  assign pos_inc   = pos_ext + CMPW'(1);
  assign word      = DATA_WIDTH'(request.item_value);
  assign idx_plus2 = XW'(lo) + XW'(2);
  assign rm_more   = (idx_plus2 < XW'(count));
  assign lo_plus2  = RW'(lo) + RW'(2);
  assign rev_more  = (lo_plus2 < RW'(hi));

  always_comb begin
    state_next = state;
    count_next = count;
    lo_next    = lo;
    hi_next    = hi;
    tmp_next   = tmp;
    fin        = 1'b0;
    fin_status = STAT_OK;
    fin_read   = '0;
    mem_we     = 1'b0;
    mem_waddr  = lo;
    mem_wdata  = mem_rdata;
    mem_re     = 1'b0;
    mem_raddr  = lo;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (request.cmd)
            CMD_APPEND: begin
              fin = 1'b1;
              if (count == CW'(DEPTH)) begin
                fin_status = STAT_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = AW'(count);
                mem_wdata  = word;
                count_next = count + CW'(1);
              end
            end
            CMD_GET: begin
              if (in_range) begin
                mem_re     = 1'b1;
                mem_raddr  = pos_addr;
                state_next = S_GET_WAIT;
              end else begin
                fin        = 1'b1;
                fin_status = STAT_OOB;
              end
            end
            CMD_SET: begin
              fin = 1'b1;
              if (in_range) begin
                mem_we    = 1'b1;
                mem_waddr = pos_addr;
                mem_wdata = word;
              end else begin
                fin_status = STAT_OOB;
              end
            end
            CMD_REMOVE: begin
              if (!in_range) begin
                fin        = 1'b1;
                fin_status = STAT_OOB;
              end else if (pos_inc < cnt_ext) begin
                // fetch the successor, then shift one entry per cycle
                mem_re     = 1'b1;
                mem_raddr  = AW'(pos_inc);
                lo_next    = pos_addr;
                state_next = S_RM_SHIFT;
              end else begin
                // last entry: only the count drops
                fin        = 1'b1;
                count_next = count - CW'(1);
              end
            end
            CMD_REVERSE: begin
              if (count > CW'(1)) begin
                mem_re     = 1'b1;
                mem_raddr  = '0;
                lo_next    = '0;
                hi_next    = AW'(count - CW'(1));
                state_next = S_REV_LO;
              end else begin
                fin = 1'b1;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_GET_WAIT: begin
        fin        = 1'b1;
        fin_read   = 32'(mem_rdata);
        state_next = S_IDLE;
      end
      S_RM_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = lo;
        mem_wdata = mem_rdata;
        if (rm_more) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(idx_plus2);
          lo_next   = lo + AW'(1);
        end else begin
          fin        = 1'b1;
          count_next = count - CW'(1);
          state_next = S_IDLE;
        end
      end
      S_REV_LO: begin
        tmp_next   = mem_rdata;
        mem_re     = 1'b1;
        mem_raddr  = hi;
        state_next = S_REV_HI;
      end
      S_REV_HI: begin
        mem_we    = 1'b1;
        mem_waddr = lo;
        mem_wdata = mem_rdata;
        if (rev_more) begin
          mem_re     = 1'b1;
          mem_raddr  = lo + AW'(1);
          state_next = S_REV_NXT;
        end else begin
          state_next = S_REV_LAST;
        end
      end
      S_REV_NXT: begin
        mem_we     = 1'b1;
        mem_waddr  = hi;
        mem_wdata  = tmp;
        tmp_next   = mem_rdata;
        lo_next    = lo + AW'(1);
        hi_next    = hi - AW'(1);
        mem_re     = 1'b1;
        mem_raddr  = hi - AW'(1);
        state_next = S_REV_HI;
      end
      S_REV_LAST: begin
        mem_we     = 1'b1;
        mem_waddr  = hi;
        mem_wdata  = tmp;
        fin        = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= fin;
    end
  end

  always_ff @(posedge clk) begin
    lo  <= lo_next;
    hi  <= hi_next;
    tmp <= tmp_next;
    if (fin) begin
      result.status      <= fin_status;
      result.read_value  <= fin_read;
      result.entry_count <= 7'(count_next);
    end
  end

  a_count_cap : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above capacity");

  a_no_rw_clash : assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write hit the same entry in one cycle");

  a_full_flag : assert property (@(posedge clk) disable iff (rst)
    (done && result.status == STAT_FULL) |-> (count == CW'(DEPTH)))
    else $error("full status while the list has room");

  a_done_cause : assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start) || $past(busy)))
    else $error("result beat without a command in flight");

endmodule

[rtl/indexed_list_engine.sv]
// Top level of the indexed list engine: an ordered list of data words.
// Instantiates ile_ctrl and ile_mem; types and codes come from ile_pkg.
//
// Usage:
//   Drive request (cmd, position, item_value) and raise start. The command
//   beat is taken at the clock edge where start is high and busy is low.
//   Each command returns exactly one result beat on result, marked by done
//   for one cycle; the receiver cannot stall, so sample it when done is high.
//   Append, set, out-of-range and unused commands are answered straight
//   from idle. Get reads the store and answers from S_GET_WAIT. Remove
//   shifts the later entries down in S_RM_SHIFT; removing the last entry
//   only drops the count. Reverse reads the low entry in S_REV_LO, swaps
//   pairs through S_REV_HI and S_REV_NXT, and ends in S_REV_LAST.
//   Remove and reverse are bounded by the single read port of the entry
//   store: one entry moves per cycle. busy drops in the cycle done is
//   shown, so the next command may be taken while the previous result
//   is on the ports.
//   Reset (rst, synchronous) empties the list; stored words need no clearing
//   since only entries below the count are ever read.
module indexed_list_engine
  import ile_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic done,
  output rsp_t result
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // store port, driven by the sequencer
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  // decode, count and walk the list
  ile_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // hold the words; read data lands in the cycle after the address
  ile_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

[bench/indexed_list_engine_tb.sv]
// Self-checking bench for indexed_list_engine: directed and random command beats.
// Tracks the list in a scoreboard class and compares every result beat with it.
// Depends on ile_pkg and the indexed_list_engine RTL.
`timescale 1ns / 1ps

module indexed_list_engine_tb;
  import ile_pkg::*;

  // Codes the block must treat as no-ops.
  localparam logic [2:0] CMD_SPARE_5 = 3'd5;
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  localparam int LIST_DEPTH   = DEPTH_DEF;
  localparam int RANDOM_BEATS = 2000;
  localparam int DRIFT_SPAN   = 150;   // beats per drift mode
  localparam int DRAIN_CYCLES = 100;   // covers a full-depth remove or reverse

  typedef enum logic [1:0] {
    FILL_UP,
    DRAIN,
    CHURN
  } drift_t;

  // Shadow of the list: predicts each result beat and checks what comes back.
  class list_shadow;
    logic [31:0] stored [LIST_DEPTH];
    int unsigned held;
    rsp_t        awaited [$];
    int unsigned mismatches;

    function new();
      held = 0;
      mismatches = 0;
    endfunction

    // Apply one accepted command beat and queue the result it must produce.
    function void note_command(req_t beat);
      rsp_t        res;
      logic [31:0] swap;
      int unsigned j;
      bit          in_range;
      in_range = beat.position < held;
      res = '0;
      res.status = STAT_OK;
      case (beat.cmd)
        CMD_APPEND: begin
          if (held >= LIST_DEPTH) begin
            res.status = STAT_FULL;
          end else begin
            stored[held] = beat.item_value;
            held++;
          end
        end
        CMD_GET: begin
          if (in_range) res.read_value = stored[beat.position];
          else res.status = STAT_OOB;
        end
        CMD_SET: begin
          if (in_range) stored[beat.position] = beat.item_value;
          else res.status = STAT_OOB;
        end
        CMD_REMOVE: begin
          if (in_range) begin
            for (int i = beat.position; i + 1 < held; i++) stored[i] = stored[i + 1];
            held--;
          end else begin
            res.status = STAT_OOB;
          end
        end
        CMD_REVERSE: begin
          for (int i = 0; i < held / 2; i++) begin
            j = held - 1 - i;
            swap = stored[i];
            stored[i] = stored[j];
            stored[j] = swap;
          end
        end
        default: ;
      endcase
      res.entry_count = held[6:0];
      awaited.push_back(res);
    endfunction

    // Compare one result beat with the oldest prediction.
    function void check_result(rsp_t got);
      rsp_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result beat with nothing outstanding: status %0d value %h count %0d",
                 $time, got.status, got.read_value, got.entry_count);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, want.status, got.status);
        mismatches++;
      end
      if (got.read_value !== want.read_value) begin
        $display("%0t: read_value mismatch: expected %h, actual %h",
                 $time, want.read_value, got.read_value);
        mismatches++;
      end
      if (got.entry_count !== want.entry_count) begin
        $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                 $time, want.entry_count, got.entry_count);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t request;
  logic done;
  rsp_t result;

  list_shadow sb = new();
  bit         no_idle;   // set for stretches with back-to-back beats

  indexed_list_engine dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Guard against a hang: the slowest legal run is far below this.
  initial begin
    #10_000_000;
    $display("[indexed_list_engine] ERROR");
    $finish;
  end

  // Check every result beat at the edge that ends its cycle.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  function automatic req_t make_beat(logic [2:0] cmd, logic [5:0] pos, logic [31:0] val);
    req_t b;
    b.cmd        = cmd;
    b.position   = pos;
    b.item_value = val;
    return b;
  endfunction

  // Hold start low for the idle gap, then present the beat until it is taken.
  // Called at a falling edge; returns at the falling edge after acceptance
  // with start still high, so a zero gap keeps the next beat back to back.
  task automatic send_command(input req_t beat, input int unsigned idle_cycles);
    if (idle_cycles > 0) begin
      start = 1'b0;
      repeat (idle_cycles) @(negedge clk);
    end
    request = beat;
    start   = 1'b1;
    do @(posedge clk); while (busy);
    sb.note_command(beat);
    @(negedge clk);
  endtask

  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(0, 19);
  endfunction

  // Build one random beat, biased by the drift mode so the list
  // swings between empty and full.
  function automatic req_t random_beat(drift_t mode, int unsigned held);
    req_t        b;
    int unsigned roll;
    int unsigned append_pct;
    int unsigned pick;
    case (mode)
      FILL_UP: append_pct = 60;
      DRAIN:   append_pct = 12;
      default: append_pct = 30;
    endcase
    roll = $urandom_range(0, 99);
    if (roll >= 97) begin
      pick = $urandom_range(0, 2);
      b.cmd = (pick == 0) ? CMD_SPARE_5 : (pick == 1) ? CMD_SPARE_6 : CMD_SPARE_7;
    end else if (roll < append_pct) begin
      b.cmd = CMD_APPEND;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 30)      b.cmd = CMD_GET;
      else if (pick < 55) b.cmd = CMD_SET;
      else if (pick < 85) b.cmd = CMD_REMOVE;
      else                b.cmd = CMD_REVERSE;
    end
    // Mostly aim inside the list, sometimes right at the end, else anywhere.
    pick = $urandom_range(0, 99);
    if (held > 0 && pick < 75)            b.position = 6'($urandom_range(0, held - 1));
    else if (pick < 85 && held < 64)      b.position = 6'(held);
    else                                  b.position = 6'($urandom_range(0, 63));
    pick = $urandom_range(0, 19);
    if (pick == 0)      b.item_value = 32'h0000_0000;
    else if (pick == 1) b.item_value = 32'hFFFF_FFFF;
    else                b.item_value = $urandom;
    return b;
  endfunction

  initial begin
    drift_t mode;
    req_t   beat;
    // Drive every input from time zero, hold reset, then release it at a falling edge.
    rst     = 1'b1;
    start   = 1'b0;
    request = '0;
    no_idle = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed beats: empty-list corners, one-entry reverse, bounds, spare codes.
    send_command(make_beat(CMD_REVERSE, 6'd0,  32'h0),         draw_gap());
    send_command(make_beat(CMD_GET,     6'd0,  32'h0),         draw_gap());
    send_command(make_beat(CMD_REMOVE,  6'd0,  32'h0),         draw_gap());
    send_command(make_beat(CMD_SET,     6'd0,  32'h1234_5678), draw_gap());
    send_command(make_beat(CMD_APPEND,  6'd63, 32'h0000_0000), draw_gap());
    send_command(make_beat(CMD_REVERSE, 6'd0,  32'h0),         draw_gap());
    send_command(make_beat(CMD_APPEND,  6'd0,  32'hFFFF_FFFF), draw_gap());
    send_command(make_beat(CMD_APPEND,  6'd0,  32'hA5A5_A5A5), draw_gap());
    send_command(make_beat(CMD_GET,     6'd0,  32'h0),         draw_gap());
    send_command(make_beat(CMD_GET,     6'd2,  32'h0),         draw_gap());
    send_command(make_beat(CMD_GET,     6'd3,  32'h0),         draw_gap());
    send_command(make_beat(CMD_GET,     6'd63, 32'h0),         draw_gap());
    send_command(make_beat(CMD_SET,     6'd1,  32'h5A5A_5A5A), draw_gap());
    send_command(make_beat(CMD_SET,     6'd3,  32'hDEAD_BEEF), draw_gap());
    send_command(make_beat(CMD_REVERSE, 6'd0,  32'h0),         draw_gap());
    send_command(make_beat(CMD_GET,     6'd0,  32'h0),         draw_gap());
    send_command(make_beat(CMD_REMOVE,  6'd1,  32'h0),         draw_gap());
    send_command(make_beat(CMD_REMOVE,  6'd1,  32'h0),         draw_gap());
    send_command(make_beat(CMD_REMOVE,  6'd5,  32'h0),         draw_gap());
    send_command(make_beat(CMD_REMOVE,  6'd0,  32'h0),         draw_gap());
    send_command(make_beat(CMD_SPARE_5, 6'd0,  32'hFFFF_FFFF), draw_gap());
    send_command(make_beat(CMD_SPARE_6, 6'd63, 32'h0),         draw_gap());
    send_command(make_beat(CMD_SPARE_7, 6'd21, 32'h1),         draw_gap());

    // Random beats: start by filling so the full-list cases come early,
    // then switch drift every span and idle behavior every 50 beats.
    mode = FILL_UP;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % DRIFT_SPAN == 0 && n > 0) begin
        case ($urandom_range(0, 2))
          0:       mode = FILL_UP;
          1:       mode = DRAIN;
          default: mode = CHURN;
        endcase
      end
      if (n % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      beat = random_beat(mode, sb.held);
      send_command(beat, draw_gap());
    end
    start = 1'b0;

    // Drain outstanding results, then give the block time to show strays.
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("[indexed_list_engine] OK");
    end else begin
      $display("[indexed_list_engine] ERROR");
    end
    $finish;
  end

endmodule
